@@ src/lfsr_count_converter_unit_defines.svh @@
// assertion macros for the lfsr count converter
// used by lfsr_count_converter_unit, no other dependencies
`ifndef LFSR_COUNT_CONVERTER_UNIT_DEFINES_SVH
`define LFSR_COUNT_CONVERTER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LCC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcc: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define LCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcc: next-cycle check failed");

`endif

@@ src/lcc_pkg.sv @@
// shared types, codes and the feedback tap table of the lfsr count converter
// no dependencies
package lcc_pkg;

    // result error codes
    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_ZERO    = 2'd1,
        ERR_NO_CONV = 2'd2,
        ERR_RANGE   = 2'd3
    } t_err;

    // conversion direction
    localparam logic CMD_TO_STATE = 1'b0;
    localparam logic CMD_TO_COUNT = 1'b1;

    localparam int CfgWidth   = 6;
    localparam int LenWidth   = 7;
    localparam int FieldWidth = 32;
    localparam int TableRows  = 65;

    localparam logic [CfgWidth-1:0] LEN_RESET = 6'd9;

    typedef logic [LenWidth-1:0] t_tap;
    typedef t_tap t_tap_row [4];

    // feedback taps per length, highest first; 0 means no tap
    localparam t_tap_row TAP_TABLE [TableRows] = '{
        '{0, 0, 0, 0}, '{0, 0, 0, 0},
        '{2, 1, 0, 0}, '{3, 2, 0, 0}, '{4, 3, 0, 0}, '{5, 3, 0, 0},
        '{6, 5, 0, 0}, '{7, 6, 0, 0}, '{8, 6, 5, 4}, '{9, 5, 0, 0},
        '{10, 7, 0, 0}, '{11, 9, 0, 0}, '{12, 11, 8, 6}, '{13, 12, 10, 9},
        '{14, 13, 11, 9}, '{15, 14, 0, 0}, '{16, 14, 13, 11}, '{17, 14, 0, 0},
        '{18, 11, 0, 0}, '{19, 18, 17, 14}, '{20, 17, 0, 0}, '{21, 19, 0, 0},
        '{22, 21, 0, 0}, '{23, 18, 0, 0}, '{24, 23, 21, 20}, '{25, 22, 0, 0},
        '{26, 25, 24, 20}, '{27, 26, 25, 22}, '{28, 25, 0, 0}, '{29, 27, 0, 0},
        '{30, 29, 26, 24}, '{31, 28, 0, 0}, '{32, 30, 26, 25}, '{33, 20, 0, 0},
        '{34, 31, 30, 26}, '{35, 33, 0, 0}, '{36, 25, 0, 0}, '{37, 36, 33, 31},
        '{38, 37, 33, 32}, '{39, 35, 0, 0}, '{40, 37, 36, 35}, '{41, 38, 0, 0},
        '{42, 40, 37, 35}, '{43, 42, 38, 37}, '{44, 42, 39, 38}, '{45, 44, 42, 41},
        '{46, 40, 39, 38}, '{47, 42, 0, 0}, '{48, 44, 41, 39}, '{49, 40, 0, 0},
        '{50, 48, 47, 46}, '{51, 50, 48, 45}, '{52, 49, 0, 0}, '{53, 52, 51, 47},
        '{54, 51, 48, 46}, '{55, 31, 0, 0}, '{56, 54, 52, 49}, '{57, 50, 0, 0},
        '{58, 39, 0, 0}, '{59, 57, 55, 52}, '{60, 59, 0, 0}, '{61, 60, 59, 56},
        '{62, 59, 57, 56}, '{63, 62, 0, 0}, '{64, 63, 61, 60}
    };

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        t_err err;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic to_count;
        logic range_err;
        logic zero_state;
        logic fwd_done;
        logic hit;
        logic last;
    } t_dp_status;

endpackage

@@ src/lcc_ctrl.sv @@
// controller state machine of the lfsr count converter
// depends on lcc_pkg
module lcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lcc_pkg::t_dp_status i_status,
    output lcc_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CHECK = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        o_cmd.err    = lcc_pkg::ERR_OK;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.to_count) begin
                    if (i_status.zero_state) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.err    = lcc_pkg::ERR_ZERO;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end else begin
                    if (i_status.range_err) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.err    = lcc_pkg::ERR_RANGE;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (i_status.to_count) begin
                    // one backward step per cycle until state one shows up or the step limit is reached
                    o_cmd.step = 1'b1;
                    if (i_status.hit) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else if (i_status.last) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.err    = lcc_pkg::ERR_NO_CONV;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    if (i_status.fwd_done) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != ST_IDLE);

endmodule

@@ src/lcc_datapath.sv @@
// lfsr state, step counter, length register and result register
// depends on lcc_pkg
module lcc_datapath #(
    parameter int MAX_STEPS  = 511,
    parameter int MAX_LENGTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lcc_pkg::CfgWidth-1:0]           i_cfg_data,
    input  logic                                   i_cmd,
    input  logic [lcc_pkg::FieldWidth-1:0]         i_operand,
    input  lcc_pkg::t_dp_cmd                       i_ctl,
    output lcc_pkg::t_dp_status                    o_status,
    output logic                                   o_valid,
    output logic [lcc_pkg::FieldWidth-1:0]         o_answer,
    output logic [1:0]                             o_error_code
);

    localparam int SW = MAX_LENGTH;
    localparam int KW = $clog2(MAX_STEPS + 1);
    localparam int FW = lcc_pkg::FieldWidth;
    localparam logic [lcc_pkg::LenWidth-1:0] MaxLen = lcc_pkg::LenWidth'(MAX_LENGTH);

    logic [lcc_pkg::CfgWidth-1:0] r_len;
    logic                         r_to_count;
    logic                         r_range_err;
    logic [SW-1:0]                r_state;
    logic [KW-1:0]                r_cnt;
    logic [SW-1:0]                r_mask;
    logic [SW-1:0]                r_top;
    logic [SW-1:0]                r_ftaps;
    logic [SW-1:0]                r_btaps;
    logic                         r_valid;
    logic [FW-1:0]                r_answer;
    lcc_pkg::t_err                r_err;

    logic [lcc_pkg::LenWidth-1:0] len_raw;
    logic [lcc_pkg::LenWidth-1:0] len_eff;
    lcc_pkg::t_tap_row            taps;
    logic [SW-1:0]                n_mask;
    logic [SW-1:0]                n_top;
    logic [SW-1:0]                n_ftaps;
    logic [SW-1:0]                n_btaps;
    logic [SW+FW-1:0]             op_wide;
    logic [SW-1:0]                op_ext;
    logic [FW-1:0]                count_n;
    logic [SW-1:0]                next_fwd;
    logic [SW-1:0]                next_back;
    logic                         fb_fwd;
    logic                         fb_back;
    logic [KW:0]                  k_steps;
    logic                         wrap;
    logic [KW+1:0]                count_out;
    logic [KW+FW+1:0]             count_wide;
    logic [SW+FW-1:0]             state_wide;
    logic [FW-1:0]                answer_ok;

    // effective length and tap vectors from the table
    always_comb begin
        len_raw = {1'b0, r_len};
        if (len_raw < lcc_pkg::LenWidth'(2)) begin
            len_eff = lcc_pkg::LenWidth'(2);
        end else if (len_raw > MaxLen) begin
            len_eff = MaxLen;
        end else begin
            len_eff = len_raw;
        end
        taps = lcc_pkg::TAP_TABLE[len_eff];
        for (int i = 0; i < SW; i++) begin
            n_mask[i]  = (lcc_pkg::LenWidth'(i) < len_eff);
            n_top[i]   = (lcc_pkg::LenWidth'(i + 1) == len_eff);
            n_ftaps[i] = 1'b0;
            n_btaps[i] = (i == 0);
            for (int k = 0; k < 4; k++) begin
                if ((taps[k] != '0) && (taps[k] == lcc_pkg::LenWidth'(i + 1))) begin
                    n_ftaps[i] = 1'b1;
                end
                if ((k != 0) && (taps[k] != '0) && (taps[k] == lcc_pkg::LenWidth'(i))) begin
                    n_btaps[i] = 1'b1;
                end
            end
        end
    end

    // operand resized to the state width
    assign op_wide = {{SW{1'b0}}, i_operand};
    assign op_ext  = op_wide[SW-1:0];
    assign count_n = i_operand;

    // one lfsr step in each direction
    assign fb_fwd    = ^(r_state & r_ftaps);
    assign next_fwd  = ({r_state[SW-2:0], fb_fwd}) & r_mask;
    assign fb_back   = ^(r_state & r_btaps);
    assign next_back = ((r_state >> 1) | (fb_back ? r_top : '0)) & r_mask;

    // count reported for a backward search, wrapping at the full period
    assign k_steps    = {1'b0, r_cnt} + (KW+1)'(1);
    assign wrap       = ({{SW{1'b0}}, k_steps} == {{(KW+1){1'b0}}, r_mask});
    assign count_out  = wrap ? (KW+2)'(1) : ({1'b0, k_steps} + (KW+2)'(1));
    assign count_wide = {{FW{1'b0}}, count_out};
    assign state_wide = {{FW{1'b0}}, r_state};
    assign answer_ok  = r_to_count ? count_wide[FW-1:0] : state_wide[FW-1:0];

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= lcc_pkg::LEN_RESET;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_to_count  <= (i_cmd == lcc_pkg::CMD_TO_COUNT);
            r_range_err <= (count_n > FW'(MAX_STEPS));
            r_mask      <= n_mask;
            r_top       <= n_top;
            r_ftaps     <= n_ftaps;
            r_btaps     <= n_btaps;
            if (i_cmd == lcc_pkg::CMD_TO_COUNT) begin
                r_state <= op_ext & n_mask;
                r_cnt   <= '0;
            end else begin
                r_state <= SW'(1);
                r_cnt   <= (count_n == '0) ? '0 : (count_n[KW-1:0] - KW'(1));
            end
        end else if (i_ctl.step) begin
            if (r_to_count) begin
                r_state <= next_back;
                r_cnt   <= r_cnt + KW'(1);
            end else begin
                r_state <= next_fwd;
                r_cnt   <= r_cnt - KW'(1);
            end
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.finish;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_err    <= i_ctl.err;
            r_answer <= (i_ctl.err == lcc_pkg::ERR_OK) ? answer_ok : '0;
        end
    end

    // status back to the controller
    assign o_status.to_count   = r_to_count;
    assign o_status.range_err  = r_range_err;
    assign o_status.zero_state = (r_state == '0);
    assign o_status.fwd_done   = (r_cnt == '0);
    assign o_status.hit        = (next_back == SW'(1));
    assign o_status.last       = (r_cnt == KW'(MAX_STEPS - 1));

    assign o_valid      = r_valid;
    assign o_answer     = r_answer;
    assign o_error_code = r_err;

endmodule

@@ src/lfsr_count_converter_unit.sv @@
// top level of the lfsr count converter: controller plus datapath
// depends on lcc_pkg, lcc_ctrl, lcc_datapath and the assertion macro header
//
//  channel   handshake            payload
//  -------   -------------------  -------------------------
//  config    i_cfg_we             i_cfg_data (register_length)
//  input     start && !busy       i_cmd, i_operand
//  result    o_valid (1 cycle)    o_answer, o_error_code
//
// a count n is converted by stepping the lfsr forward from state one, one lfsr
// step per cycle; a backward search steps back until state one shows up, and
// gives up at the step limit MAX_STEPS; range and zero-state errors are found
// on entry. the single lfsr state register and step logic serve both directions.
// synchronous active-low reset clears the controller, strobe and length (9).
// busy is high from accept until the result cycle; results cannot be stalled.
`include "lfsr_count_converter_unit_defines.svh"

module lfsr_count_converter_unit #(
    parameter int MAX_STEPS  = 511,
    parameter int MAX_LENGTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lcc_pkg::CfgWidth-1:0]   i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cmd,
    input  logic [lcc_pkg::FieldWidth-1:0] i_operand,
    output logic                           o_valid,
    output logic [lcc_pkg::FieldWidth-1:0] o_answer,
    output logic [1:0]                     o_error_code
);

    lcc_pkg::t_dp_cmd    ctl;
    lcc_pkg::t_dp_status status;

    // sequencing
    lcc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (ctl)
    );

    // lfsr datapath
    lcc_datapath #(
        .MAX_STEPS  (MAX_STEPS),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (i_cmd),
        .i_operand    (i_operand),
        .i_ctl        (ctl),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_answer     (o_answer),
        .o_error_code (o_error_code)
    );

    // checks
    `LCC_ASSERT_SAME(a_err_answer_zero, i_clk, i_rst_n, o_valid && (o_error_code != lcc_pkg::ERR_OK), o_answer == '0)
    `LCC_ASSERT_NEXT(a_accept_sets_busy, i_clk, i_rst_n, start && !busy, busy)
    `LCC_ASSERT_SAME(a_result_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    `LCC_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

endmodule
